// ----- hdl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescape core.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int CP_W      = 16;
   localparam int MAX_RSP   = 4;
   localparam int CNT_W     = $clog2(MAX_RSP + 1);
   localparam int SLOT_W    = $clog2(MAX_RSP);

   // scan modes
   localparam logic [1:0] MODE_WAIT = 2'd0;
   localparam logic [1:0] MODE_TEXT = 2'd1;
   localparam logic [1:0] MODE_ESC  = 2'd2;
   localparam logic [1:0] MODE_HEX  = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NUL    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOOPEN = 2'd3;

   // characters
   localparam logic [BYTE_W-1:0] CHR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHR_BSL   = 8'h5C;
   localparam logic [BYTE_W-1:0] CHR_U     = 8'h75;

   typedef struct packed {
      logic [1:0]      mode;
      logic [1:0]      digits;
      logic [CP_W-1:0] cp;
   } scan_state_type;

   typedef struct packed {
      logic [CNT_W-1:0]                count;
      logic [MAX_RSP-1:0][BYTE_W-1:0]  data;
      logic [MAX_RSP-1:0][KIND_W-1:0]  kind;
   } burst_type;

   function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] h);
      logic [3:0] v;
      v = 4'd0;
      if (h >= 8'h30 && h <= 8'h39)      v = 4'(h - 8'h30);
      else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
      else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
      return v;
   endfunction

   function automatic logic [BYTE_W-1:0] escape_map(input logic [BYTE_W-1:0] e);
      logic [BYTE_W-1:0] r;
      r = e;
      if (e == 8'h6E)      r = 8'h0A;
      else if (e == 8'h74) r = 8'h09;
      else if (e == 8'h72) r = 8'h0D;
      else if (e == 8'h62) r = 8'h08;
      else if (e == 8'h66) r = 8'h0C;
      return r;
   endfunction

   function automatic burst_type empty_burst();
      burst_type b;
      b.count = '0;
      b.data  = '0;
      b.kind  = {MAX_RSP{KIND_DATA}};
      return b;
   endfunction

   // one to three utf-8 bytes
   function automatic burst_type utf8_burst(input logic [CP_W-1:0] cp);
      burst_type b;
      b = empty_burst();
      if (cp < 16'h0080) begin
         b.count   = CNT_W'(1);
         b.data[0] = cp[7:0];
      end else if (cp < 16'h0800) begin
         b.count   = CNT_W'(2);
         b.data[0] = 8'hC0 | {3'b000, cp[10:6]};
         b.data[1] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         b.count   = CNT_W'(3);
         b.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
         b.data[1] = 8'h80 | {2'b00, cp[11:6]};
         b.data[2] = 8'h80 | {2'b00, cp[5:0]};
      end
      return b;
   endfunction

   // append a terminating result of the given kind
   function automatic burst_type add_end(input burst_type b_in,
                                         input logic [KIND_W-1:0] k);
      burst_type b;
      b = b_in;
      b.data[b_in.count[SLOT_W-1:0]] = '0;
      b.kind[b_in.count[SLOT_W-1:0]] = k;
      b.count = b_in.count + CNT_W'(1);
      return b;
   endfunction

endpackage

// ----- hdl/jsu_ifs.sv -----
// ----------------------------------------------------------------------------
// jsu channel interfaces
// Valid/ready channels for text bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] out_kind;
   logic       out_last;

   modport source (output valid, output out_byte, output out_kind, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input out_kind, input out_last,
                   output ready);
endinterface

// ----- hdl/json_string_unescape_core.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Decodes quoted JSON strings from a byte stream into unescaped UTF-8 bytes.
// ----------------------------------------------------------------------------
// req_ch carries one text byte per transfer; rsp_ch carries decoded results,
// each with a data byte, a kind (data, closed, ended by NUL, no opening quote)
// and a last flag on the final result caused by one text byte.
// A text byte is decoded in the cycle it is accepted and its burst of zero to
// four results is registered, so its first result appears in the next cycle.
// The burst register drains one result per cycle while rsp_ch is ready; a new
// text byte is taken when the register is empty or its last result transfers
// in the same cycle. Bytes that give at most one result therefore stream at
// one byte per cycle while rsp_ch is ready; a byte giving more results holds
// the input until its last result transfers, as there is a single result port.
// Reset empties the burst register and returns the scanner to waiting for an
// opening quote. While rsp_ch is stalled the current result holds and req_ch
// stays not ready once the burst register's last result is waiting.
// ----------------------------------------------------------------------------
module json_string_unescape_core (
   input  logic       clock,
   input  logic       reset,
   jsu_req_if.sink    req_ch,
   jsu_rsp_if.source  rsp_ch
);
   import jsu_pkg::*;

   scan_state_type                 state_ff, state_in;
   burst_type                      burst;
   logic [CNT_W-1:0]               rem_ff, rem_in;
   logic [MAX_RSP-1:0][BYTE_W-1:0] data_ff, data_in;
   logic [MAX_RSP-1:0][KIND_W-1:0] kind_ff, kind_in;
   scan_state_type                 dec_state;
   logic                           req_xfer, rsp_xfer;

   jsu_decode u_decode (
      .cur_state (state_ff),
      .in_byte   (req_ch.in_byte),
      .nxt_state (dec_state),
      .burst     (burst)
   );

   assign rsp_xfer     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (rem_ff == '0) || ((rem_ff == CNT_W'(1)) && rsp_ch.ready);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid    = (rem_ff != '0);
   assign rsp_ch.out_byte = data_ff[0];
   assign rsp_ch.out_kind = kind_ff[0];
   assign rsp_ch.out_last = (rem_ff == CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      data_in  = data_ff;
      kind_in  = kind_ff;
      priority if (req_xfer) begin
         state_in = dec_state;
         rem_in   = burst.count;
         data_in  = burst.data;
         kind_in  = burst.kind;
      end else if (rsp_xfer) begin
         rem_in = rem_ff - CNT_W'(1);
         for (int i = 0; i < MAX_RSP - 1; i++) begin
            data_in[i] = data_ff[i+1];
            kind_in[i] = kind_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode   <= MODE_WAIT;
         state_ff.digits <= 2'd0;
         state_ff.cp     <= '0;
         rem_ff          <= '0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
      end
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

   // a burst keeps presenting until its last result transfers
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_ch.out_last) |=> rsp_ch.valid)
      else $error("burst broke before its last result");

   // no new byte while a non-final result is pending
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.out_last) |-> !req_ch.ready)
      else $error("input accepted over a pending burst");

   // only the final result of a burst may carry a status kind
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.out_last) |-> (rsp_ch.out_kind == KIND_DATA))
      else $error("status kind before end of burst");

   // hex gathering state is clear outside hex mode
   a_hex_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode != MODE_HEX) |-> (state_ff.digits == 2'd0 && state_ff.cp == '0))
      else $error("stale hex state outside hex mode");

endmodule

// ----- hdl/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// Per-byte scan step: next scan state and the burst of results for one byte.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  jsu_pkg::scan_state_type cur_state,
   input  logic [7:0]              in_byte,
   output jsu_pkg::scan_state_type nxt_state,
   output jsu_pkg::burst_type      burst
);
   import jsu_pkg::*;

   logic [CP_W-1:0] shifted_cp;

   assign shifted_cp = {cur_state.cp[CP_W-5:0], hex_value(in_byte)};

   always_comb begin
      nxt_state = cur_state;
      burst     = empty_burst();
      unique case (cur_state.mode)
         MODE_WAIT: begin
            if (in_byte == CHR_QUOTE) nxt_state.mode = MODE_TEXT;
            else                      burst = add_end(empty_burst(), KIND_NOOPEN);
         end
         MODE_TEXT: begin
            priority if (in_byte == CHR_NUL) begin
               burst          = add_end(empty_burst(), KIND_NUL);
               nxt_state.mode = MODE_WAIT;
            end else if (in_byte == CHR_QUOTE) begin
               burst          = add_end(empty_burst(), KIND_CLOSED);
               nxt_state.mode = MODE_WAIT;
            end else if (in_byte == CHR_BSL) begin
               nxt_state.mode = MODE_ESC;
            end else begin
               burst.count   = CNT_W'(1);
               burst.data[0] = in_byte;
            end
         end
         MODE_ESC: begin
            priority if (in_byte == CHR_NUL) begin
               burst          = add_end(empty_burst(), KIND_NUL);
               nxt_state.mode = MODE_WAIT;
            end else if (in_byte == CHR_U) begin
               nxt_state.mode   = MODE_HEX;
               nxt_state.digits = 2'd0;
               nxt_state.cp     = '0;
            end else begin
               burst.count    = CNT_W'(1);
               burst.data[0]  = escape_map(in_byte);
               nxt_state.mode = MODE_TEXT;
            end
         end
         MODE_HEX: begin
            priority if (in_byte == CHR_NUL) begin
               burst            = add_end(utf8_burst(cur_state.cp), KIND_NUL);
               nxt_state.mode   = MODE_WAIT;
               nxt_state.digits = 2'd0;
               nxt_state.cp     = '0;
            end else if (cur_state.digits == 2'd3) begin
               burst            = utf8_burst(shifted_cp);
               nxt_state.mode   = MODE_TEXT;
               nxt_state.digits = 2'd0;
               nxt_state.cp     = '0;
            end else begin
               nxt_state.cp     = shifted_cp;
               nxt_state.digits = cur_state.digits + 2'd1;
            end
         end
      endcase
   end

endmodule

// ----- bench/jsu_checker.sv -----
// ----------------------------------------------------------------------------
// jsu_checker
// Watches both channels of the JSON string unescape core, decodes every
// accepted text byte on its own and compares each result transfer, field by
// field, with the oldest outstanding decoded result.
// ----------------------------------------------------------------------------
module jsu_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [jsu_pkg::BYTE_W-1:0] req_byte,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [jsu_pkg::BYTE_W-1:0] rsp_byte,
   input  logic [jsu_pkg::KIND_W-1:0] rsp_kind,
   input  logic                      rsp_last,
   output int unsigned               error_count,
   output int unsigned               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import jsu_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [KIND_W-1:0] kind;
      logic              last;
   } decoded_type;

   decoded_type     expected_results[$];
   decoded_type     burst[$];
   logic [1:0]      scan_mode;
   logic [1:0]      digit_count;
   logic [CP_W-1:0] code_point;

   function automatic logic [3:0] hex_digit(input logic [BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
   endfunction

   function automatic logic [BYTE_W-1:0] unescaped(input logic [BYTE_W-1:0] c);
      case (c)
         "n": return 8'h0A;
         "t": return 8'h09;
         "r": return 8'h0D;
         "b": return 8'h08;
         "f": return 8'h0C;
         default: return c;
      endcase
   endfunction

   task automatic emit(input logic [BYTE_W-1:0] d, input logic [KIND_W-1:0] k);
      burst.push_back('{data: d, kind: k, last: 1'b0});
   endtask

   task automatic emit_utf8(input logic [CP_W-1:0] c);
      if (c < 16'h0080) begin
         emit(c[7:0], KIND_DATA);
      end else if (c < 16'h0800) begin
         emit({3'b110, c[10:6]}, KIND_DATA);
         emit({2'b10, c[5:0]}, KIND_DATA);
      end else begin
         emit({4'b1110, c[15:12]}, KIND_DATA);
         emit({2'b10, c[11:6]}, KIND_DATA);
         emit({2'b10, c[5:0]}, KIND_DATA);
      end
   endtask

   task automatic decode_text_byte(input logic [BYTE_W-1:0] b);
      logic [CP_W-1:0] next_cp;
      burst.delete();
      next_cp = {code_point[CP_W-5:0], hex_digit(b)};
      case (scan_mode)
         MODE_WAIT: begin
            if (b == CHR_QUOTE) scan_mode = MODE_TEXT;
            else emit('0, KIND_NOOPEN);
         end
         MODE_TEXT: begin
            if (b == CHR_NUL) begin
               emit('0, KIND_NUL);
               scan_mode = MODE_WAIT;
            end else if (b == CHR_QUOTE) begin
               emit('0, KIND_CLOSED);
               scan_mode = MODE_WAIT;
            end else if (b == CHR_BSL) begin
               scan_mode = MODE_ESC;
            end else begin
               emit(b, KIND_DATA);
            end
         end
         MODE_ESC: begin
            if (b == CHR_NUL) begin
               emit('0, KIND_NUL);
               scan_mode = MODE_WAIT;
            end else if (b == CHR_U) begin
               scan_mode   = MODE_HEX;
               digit_count = '0;
               code_point  = '0;
            end else begin
               emit(unescaped(b), KIND_DATA);
               scan_mode = MODE_TEXT;
            end
         end
         default: begin
            // NUL flushes the partial code point before ending the string
            if (b == CHR_NUL) begin
               emit_utf8(code_point);
               emit('0, KIND_NUL);
               scan_mode   = MODE_WAIT;
               digit_count = '0;
               code_point  = '0;
            end else if (digit_count == 2'd3) begin
               emit_utf8(next_cp);
               scan_mode   = MODE_TEXT;
               digit_count = '0;
               code_point  = '0;
            end else begin
               code_point  = next_cp;
               digit_count = digit_count + 2'd1;
            end
         end
      endcase
      if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_results.push_back(burst[i]);
   endtask

   task automatic count_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   task automatic check_result();
      decoded_type got;
      decoded_type want;
      got = '{data: rsp_byte, kind: rsp_kind, last: rsp_last};
      if (expected_results.size() == 0) begin
         count_error($sformatf("unexpected result: byte %h kind %0d last %0d",
                               got.data, got.kind, got.last));
      end else begin
         want = expected_results.pop_front();
         if (got !== want)
            count_error($sformatf(
               "mismatch: expected byte %h kind %0d last %0d, got byte %h kind %0d last %0d",
               want.data, want.kind, want.last, got.data, got.kind, got.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_mode   = MODE_WAIT;
         digit_count = '0;
         code_point  = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) decode_text_byte(req_byte);
      end
      pending_count <= expected_results.size();
   end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives quoted JSON strings into the unescape core, a directed run through
// escapes, unicode escapes and early ends followed by random strings with
// some noise, under random stalls on both channels; the checker decodes and
// compares every result transfer.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import jsu_pkg::*;

   logic        clock;
   logic        reset;
   int unsigned error_count;
   int unsigned pending_count;
   int unsigned sent_count = 0;
   bit          req_calm   = 1'b0;
   bit          rsp_calm   = 1'b0;
   string       hex_chars    = "0123456789abcdefABCDEF";
   string       escape_chars = "ntrbf/\\\"";

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   json_string_unescape_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   jsu_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_byte      (req_ch.in_byte),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_byte      (rsp_ch.out_byte),
      .rsp_kind      (rsp_ch.out_kind),
      .rsp_last      (rsp_ch.out_last),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 16));
   endfunction

   // called right after a rising edge; returns at the edge of the transfer
   task automatic send_text_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 23) == 0) req_calm = !req_calm;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sent_count++;
   endtask

   task automatic drive_result_ready();
      int gap;
      forever begin
         if ($urandom_range(0, 23) == 0) rsp_calm = !rsp_calm;
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   endtask

   // leading zeros steer the code point toward one, two or three utf-8 bytes
   task automatic send_hex_digits(input int count);
      int         cls;
      int         zeros;
      logic [7:0] c;
      cls   = $urandom_range(0, 2);
      zeros = 2 - cls;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(1, 255));
         else if (k < zeros) c = "0";
         else if (k == zeros && cls < 2) c = 8'("0" + $urandom_range(0, 7));
         else c = hex_chars[$urandom_range(0, 21)];
         send_text_byte(c);
      end
   endtask

   task automatic send_element();
      int         pick;
      logic [7:0] c;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         do c = 8'($urandom_range(1, 255)); while (c == CHR_QUOTE || c == CHR_BSL);
         send_text_byte(c);
      end else begin
         send_text_byte(CHR_BSL);
         if (pick < 7) begin
            send_text_byte(escape_chars[$urandom_range(0, 7)]);
         end else if (pick < 9) begin
            send_text_byte(CHR_U);
            send_hex_digits(4);
         end else begin
            do c = 8'($urandom_range(1, 255)); while (c == CHR_U);
            send_text_byte(c);
         end
      end
   endtask

   task automatic send_random_string();
      int         ending;
      logic [7:0] c;
      // noise while no string is open
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            do c = 8'($urandom_range(0, 255)); while (c == CHR_QUOTE);
            send_text_byte(c);
         end
      end
      send_text_byte(CHR_QUOTE);
      repeat ($urandom_range(0, 8)) send_element();
      ending = $urandom_range(0, 9);
      if (ending < 7) begin
         send_text_byte(CHR_QUOTE);
      end else if (ending == 7) begin
         send_text_byte(CHR_NUL);
      end else begin
         send_text_byte(CHR_BSL);
         if (ending == 9) begin
            send_text_byte(CHR_U);
            send_hex_digits($urandom_range(0, 3));
         end
         send_text_byte(CHR_NUL);
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = '{"x", CHR_NUL,
                   CHR_QUOTE, 8'hFF, CHR_BSL, CHR_U, "F", "f", CHR_QUOTE, CHR_BSL,
                   CHR_QUOTE,
                   CHR_QUOTE, CHR_BSL, CHR_NUL,
                   CHR_QUOTE, CHR_BSL, CHR_U, CHR_NUL,
                   CHR_QUOTE, CHR_BSL, CHR_U, "8", "0", "0", CHR_NUL,
                   CHR_QUOTE, CHR_NUL};
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= '0;
      rsp_ch.ready   <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         drive_result_ready();
      join_none
      foreach (directed[i]) send_text_byte(directed[i]);
      while (sent_count < 420) send_random_string();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/jsu_pkg.sv
hdl/jsu_ifs.sv
hdl/jsu_decode.sv
hdl/json_string_unescape_core.sv
bench/jsu_checker.sv
bench/testbench.sv
